// ===== rtl/core/ill_pkg.sv =====
// Shared types and constants for the indexed insert/erase list.
// No dependencies; imported by the list top level.
package ill_pkg;

  // Default storage shape
  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths of the stream items
  localparam int CMD_BITS    = 2;
  localparam int INDEX_BITS  = 5;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;
  localparam int IN_BITS     = 40;
  localparam int OUT_BITS    = 40;

  // Command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/indexed_insert_erase_list.sv =====
// Indexed insert/erase list: ordered word list kept in one synchronous RAM.
// Depends on ill_pkg for command codes, status codes and field widths.
//
// Usage:
//   Input channel s_axis_*: one command item per handshake (append, insert
//   at index, erase at index, read at index). Output channel m_axis_*: one
//   result item per command with the read word, count, empty flag, status.
//   The block works on one command at a time. Append, insert at the end,
//   erase of the last entry and a failed command go straight to the result
//   step (S_DONE); a read first passes S_LAST to take the RAM read data;
//   insert and erase below the end pass S_MOVE and S_LAST, and insert then
//   S_PUT to write the new word, before S_DONE. The next command is
//   accepted only once S_DONE has handed the result to the output register.
//   Insert and erase move one entry per cycle through the single RAM read
//   and write port (read entry, write it one place over next cycle); that
//   move loop sets the time for those commands. s_axis_tready is high only
//   while the sequencer is idle.
//   The result sits in an output register, so a new command is taken while
//   an earlier result still waits; a stalled receiver holds the block at
//   its final step until the output register frees up.
//   Reset empties the list (count zero); RAM contents are not cleared and
//   never need to be, since only written entries below count are read.
module indexed_insert_erase_list
  import ill_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Command items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: command[1:0], index[6:2], value[38:7], zero pad[39]
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  // Result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: read_value[31:0], count[36:32], empty_res[37], status[39:38]
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam int OW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int XW = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOVE = 5'b00010,
    S_LAST = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cnt_res;
  cmd_t                   cmd_q;
  logic [AW-1:0]          idx_q;
  logic [WORD_BITS-1:0]   word_q;
  logic [STATUS_BITS-1:0] status_q;
  logic [VALUE_BITS-1:0]  rd_val;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          end_addr;
  logic [AW-1:0]          prev_addr;
  logic                   have;

  // RAM
  logic [WORD_BITS-1:0]   mem [CAPACITY];
  logic [WORD_BITS-1:0]   mem_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [WORD_BITS-1:0]   mem_wd;
  logic [AW-1:0]          mem_ra;

  // Input field decode
  cmd_t                   in_cmd;
  logic [KW-1:0]          in_idx;
  logic [KW-1:0]          cnt_k;
  logic [AW-1:0]          idx_a;
  logic [XW-1:0]          val_ext;
  logic [WORD_BITS-1:0]   in_word;
  logic                   accept;
  logic                   full;
  logic [AW-1:0]          cnt_a;
  logic [AW-1:0]          cnt_m1_a;
  logic [CW-1:0]          cnt_m1;
  logic [AW-1:0]          move_wa;
  logic [XW-1:0]          rd_ext;
  logic [OW-1:0]          cnt_ext;
  logic                   out_free;

  assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
  assign in_idx   = KW'(s_axis_tdata[6:2]);
  assign val_ext  = XW'(s_axis_tdata[38:7]);
  assign in_word  = val_ext[WORD_BITS-1:0];
  assign cnt_k    = KW'(cnt);
  assign idx_a    = in_idx[AW-1:0];
  assign full     = (cnt == CW'(CAPACITY));
  assign cnt_a    = cnt[AW-1:0];
  assign cnt_m1   = cnt - 1'b1;
  assign cnt_m1_a = cnt_m1[AW-1:0];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_ext   = XW'(mem_q);
  assign cnt_ext  = OW'(cnt_res);

  assign s_axis_tready = (state == S_IDLE);

  // Move target: one place up for insert, one place down for erase
  assign move_wa = (cmd_q == CMD_INSERT) ? prev_addr + 1'b1 : prev_addr - 1'b1;

  // Select RAM write and read ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = prev_addr;
    mem_wd = mem_q;
    mem_ra = rd_addr;
    case (state)
      S_IDLE: begin
        mem_ra = idx_a;
        mem_wd = in_word;
        if (accept && in_cmd == CMD_APPEND && !full) begin
          mem_we = 1'b1;
          mem_wa = cnt_a;
        end else if (accept && in_cmd == CMD_INSERT && in_idx == cnt_k && !full) begin
          mem_we = 1'b1;
          mem_wa = idx_a;
        end
      end
      S_MOVE: begin
        mem_we = have;
        mem_wa = move_wa;
      end
      S_LAST: begin
        mem_we = (cmd_q != CMD_READ);
        mem_wa = move_wa;
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = idx_q;
        mem_wd = word_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // RAM with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // Command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      have          <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= in_cmd;
            idx_q    <= idx_a;
            word_q   <= in_word;
            rd_val   <= '0;
            status_q <= ST_OK;
            cnt_res  <= cnt;
            have     <= 1'b0;
            state    <= S_DONE;
            case (in_cmd)
              CMD_APPEND: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  cnt_res <= cnt + 1'b1;
                end
              end
              CMD_INSERT: begin
                if (in_idx > cnt_k) begin
                  status_q <= ST_RANGE;
                end else if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  cnt_res <= cnt + 1'b1;
                  if (in_idx != cnt_k) begin
                    rd_addr  <= cnt_m1_a;
                    end_addr <= idx_a;
                    state    <= S_MOVE;
                  end
                end
              end
              CMD_ERASE: begin
                if (in_idx >= cnt_k) begin
                  status_q <= ST_RANGE;
                end else begin
                  cnt_res <= cnt_m1;
                  if (idx_a != cnt_m1_a) begin
                    rd_addr  <= idx_a + 1'b1;
                    end_addr <= cnt_m1_a;
                    state    <= S_MOVE;
                  end
                end
              end
              default: begin
                if (in_idx >= cnt_k) begin
                  status_q <= ST_RANGE;
                end else begin
                  state <= S_LAST;
                end
              end
            endcase
          end
        end
        S_MOVE: begin
          // Advance the read pointer; each entry is written in the cycle after its read
          have      <= 1'b1;
          prev_addr <= rd_addr;
          if (rd_addr == end_addr) begin
            state <= S_LAST;
          end else if (cmd_q == CMD_INSERT) begin
            rd_addr <= rd_addr - 1'b1;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end
        S_LAST: begin
          if (cmd_q == CMD_READ) begin
            rd_val <= rd_ext[VALUE_BITS-1:0];
            state  <= S_DONE;
          end else if (cmd_q == CMD_INSERT) begin
            state <= S_PUT;
          end else begin
            state <= S_DONE;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free, then commit the count
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {status_q, (cnt_res == '0), cnt_ext[COUNT_BITS-1:0], rd_val};
            cnt           <= cnt_res;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Count never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Move reads stay inside the stored entries
  a_move_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (CW'(rd_addr) < cnt))
    else $error("move read beyond stored entries");

  // A full report leaves the list at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && status_q == ST_FULL) |=> (cnt == CW'(CAPACITY)))
    else $error("full status without a full list");

  // A new item is taken only with the sequencer idle, which then leaves idle
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accepting an item");

endmodule
